FILE: rtl/mlpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types and constants of the multichannel light peak finder.
// ----------------------------------------------------------------------------
package mlpf_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_BITS     = 3;
  localparam int SAMPLE_BITS = 10;
  localparam int WEIGHT_BITS = 8;
  localparam int LEVEL_BITS  = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_MARGIN   = 1'd1;

  // Command handed from the front to the back end
  typedef struct packed {
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   scan;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic                  peak_found;
    logic [CH_BITS-1:0]    peak_channel;
    logic [LEVEL_BITS-1:0] peak_value;
    logic [LEVEL_BITS-1:0] mean_level;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_WR,
    B_SCAN,
    B_OUT
  } back_state_t;

endpackage

FILE: rtl/multichannel_light_peak_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_light_peak_finder_unit
// Per-channel exponential light filter with end-of-scan peak and mean report.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (in_push/in_full): one sample transaction with its channel.
//   Channels at or beyond CHANNELS are accepted and dropped. A sample on the
//   highest channel updates that level and then triggers a scan, which yields
//   one result transaction on the output queue (out_empty/out_pop).
//   Config port: cfg_we with cfg_index selects filter weight or peak margin.
// Operation:
//   The back end filters each sample in a multiply state, then a write-back
//   state; back-to-back samples pass through the 2-deep command queue with
//   no return to idle between them. A scan walks every level in the scan
//   state, posts the result in the output state and returns to idle; the
//   mean is the sum shifted right.
// Reset and stall:
//   Reset clears all levels to zero, loads weight 128 and margin 50, and
//   empties both queues. If the receiver stalls, results wait in a 2-deep
//   output queue; when it fills, the back end holds, then in_full rises.
// ----------------------------------------------------------------------------
module multichannel_light_peak_finder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [mlpf_pkg::CH_BITS-1:0]     in_channel,
  input  logic [mlpf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_peak_found,
  output logic [mlpf_pkg::CH_BITS-1:0]     out_peak_channel,
  output logic [mlpf_pkg::LEVEL_BITS-1:0]  out_peak_value,
  output logic [mlpf_pkg::LEVEL_BITS-1:0]  out_mean_level,
  input  logic                            cfg_we,
  input  logic [mlpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [mlpf_pkg::WEIGHT_BITS-1:0] filter_weight_r;
  logic [mlpf_pkg::LEVEL_BITS-1:0]  peak_margin_r;

  mlpf_pkg::cmd_t cmd_in, cmd_head;
  mlpf_pkg::res_t res_in, res_head;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_weight_r <= 8'd128;
      peak_margin_r   <= 10'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlpf_pkg::REG_FILTER_WEIGHT: filter_weight_r <= cfg_data[mlpf_pkg::WEIGHT_BITS-1:0];
        mlpf_pkg::REG_PEAK_MARGIN:   peak_margin_r   <= cfg_data[mlpf_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  mlpf_front u_front (
    .in_push    (in_push),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .in_full    (in_full),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  mlpf_fifo #(.WIDTH($bits(mlpf_pkg::cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  mlpf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .filter_weight (filter_weight_r),
    .peak_margin   (peak_margin_r),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_head),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  mlpf_fifo #(.WIDTH($bits(mlpf_pkg::res_t)), .DEPTH(2)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .head      (res_head),
    .empty     (out_empty)
  );

  assign out_peak_found   = res_head.peak_found;
  assign out_peak_channel = res_head.peak_channel;
  assign out_peak_value   = res_head.peak_value;
  assign out_mean_level   = res_head.mean_level;

endmodule

FILE: rtl/mlpf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpf_fifo
// Small register queue with push/full and pop/empty; head shown while not empty.
// ----------------------------------------------------------------------------
module mlpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/mlpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpf_front
// Accepts sample transactions, drops out-of-range channels, tags scan triggers.
// ----------------------------------------------------------------------------
module mlpf_front (
  input  logic                            in_push,
  input  logic [mlpf_pkg::CH_BITS-1:0]     in_channel,
  input  logic [mlpf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            in_full,
  input  logic                            cmd_full,
  output logic                            cmd_push,
  output mlpf_pkg::cmd_t                  cmd
);

  localparam int CMP_W = 5;

  logic in_range;
  logic is_last;

  assign in_range = (CMP_W'(in_channel) < CMP_W'(mlpf_pkg::CHANNELS));
  assign is_last  = (CMP_W'(in_channel) == CMP_W'(mlpf_pkg::CHANNELS - 1));

  // Hold off only when the command queue cannot take the transaction
  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full && in_range;

  always_comb begin
    cmd.channel = in_channel;
    cmd.sample  = in_sample;
    cmd.scan    = is_last;
  end

endmodule

FILE: rtl/mlpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpf_back
// Filters the stored level of each command's channel and, on a scan command,
// walks all levels, takes the mean and builds a result.
// ----------------------------------------------------------------------------
module mlpf_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mlpf_pkg::WEIGHT_BITS-1:0] filter_weight,
  input  logic [mlpf_pkg::LEVEL_BITS-1:0]  peak_margin,
  input  logic                            cmd_empty,
  input  mlpf_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  input  logic                            res_full,
  output logic                            res_push,
  output mlpf_pkg::res_t                  res
);

  localparam int CHANNELS = mlpf_pkg::CHANNELS;
  localparam int LW    = mlpf_pkg::LEVEL_BITS;
  localparam int SW    = mlpf_pkg::SAMPLE_BITS;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = LW + $clog2(CHANNELS);
  localparam int PROD_W = LW + mlpf_pkg::WEIGHT_BITS + 2;

  mlpf_pkg::back_state_t state_r, state_nxt;

  logic [LW-1:0]     levels_r [CHANNELS];
  logic [CH_W-1:0]   ch_r;
  logic [SW-1:0]     smp_r;
  logic              scan_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [CH_W-1:0]   idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [LW-1:0]     best_r;
  logic [CH_W-1:0]   best_ch_r;

  logic              load_cmd;
  logic              idx_last;
  logic [LW-1:0]     old_level;
  logic [LW-1:0]     scan_level;
  logic signed [LW:0]   diff;
  logic signed [PROD_W-1:0] acc;
  logic [LW-1:0]     new_level;
  logic [LW-1:0]     mean;
  logic              found;

  assign old_level  = levels_r[ch_r];
  assign scan_level = levels_r[idx_r];
  assign idx_last   = (idx_r == CH_W'(CHANNELS - 1));

  // new = (sample*256 + w*(old - sample)) >> 8, same integer as the two-product form
  assign diff      = $signed({1'b0, old_level}) - $signed({1'b0, smp_r});
  assign acc       = $signed(PROD_W'({smp_r, 8'b0})) + prod_r;
  assign new_level = acc[LW+7:8];

  // Channel count is a power of two, so the mean is the sum shifted right
  assign mean  = LW'(sum_r / SUM_W'(CHANNELS));
  assign found = ((best_r - mean) >= peak_margin);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlpf_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = mlpf_pkg::B_MUL;
        end
      end
      mlpf_pkg::B_MUL: state_nxt = mlpf_pkg::B_WR;
      mlpf_pkg::B_WR: begin
        if (scan_r) begin
          state_nxt = mlpf_pkg::B_SCAN;
        end else if (!cmd_empty) begin
          state_nxt = mlpf_pkg::B_MUL;
        end else begin
          state_nxt = mlpf_pkg::B_IDLE;
        end
      end
      mlpf_pkg::B_SCAN: begin
        if (idx_last) begin
          state_nxt = mlpf_pkg::B_OUT;
        end
      end
      mlpf_pkg::B_OUT: begin
        if (!res_full) begin
          state_nxt = mlpf_pkg::B_IDLE;
        end
      end
      default: state_nxt = mlpf_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    load_cmd = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      mlpf_pkg::B_IDLE: load_cmd = !cmd_empty;
      mlpf_pkg::B_WR:   load_cmd = !scan_r && !cmd_empty;
      mlpf_pkg::B_OUT:  res_push = !res_full;
      default: begin
        load_cmd = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  assign cmd_pop = load_cmd;

  always_comb begin
    res.peak_found   = found;
    res.peak_channel = found ? mlpf_pkg::CH_BITS'(best_ch_r) : '0;
    res.peak_value   = found ? best_r : '0;
    res.mean_level   = mean;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlpf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        levels_r[i] <= '0;
      end
    end else if (state_r == mlpf_pkg::B_WR) begin
      levels_r[ch_r] <= new_level;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      ch_r   <= CH_W'(cmd.channel);
      smp_r  <= cmd.sample;
      scan_r <= cmd.scan;
    end
    if (state_r == mlpf_pkg::B_MUL) begin
      prod_r <= $signed({1'b0, filter_weight}) * diff;
    end
    case (state_r)
      mlpf_pkg::B_WR: begin
        idx_r     <= '0;
        sum_r     <= '0;
        best_r    <= '0;
        best_ch_r <= '0;
      end
      mlpf_pkg::B_SCAN: begin
        sum_r <= sum_r + SUM_W'(scan_level);
        idx_r <= idx_r + 1'b1;
        // strict compare keeps the first channel holding the maximum
        if (scan_level > best_r) begin
          best_r    <= scan_level;
          best_ch_r <= idx_r;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/mlpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpf_checker
// Port-level checks of the peak finder, bound to the top level.
// ----------------------------------------------------------------------------
module mlpf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic                            out_peak_found,
  input logic [mlpf_pkg::CH_BITS-1:0]     out_peak_channel,
  input logic [mlpf_pkg::LEVEL_BITS-1:0]  out_peak_value,
  input logic [mlpf_pkg::LEVEL_BITS-1:0]  out_mean_level
);

  // Both queues drain at reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_peak_found)
      && $stable(out_peak_channel) && $stable(out_peak_value)
      && $stable(out_mean_level)))
    else $error("stalled result changed");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_peak_found) |-> (out_peak_channel == '0 && out_peak_value == '0))
    else $error("no-peak result carries channel or value");

  a_peak_above_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_peak_found) |-> (out_peak_value >= out_mean_level))
    else $error("peak below mean");

endmodule

bind multichannel_light_peak_finder_unit mlpf_checker u_mlpf_checker (.*);

FILE: tb/sv/tb_multichannel_light_peak_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_light_peak_finder_unit
// Self-checking bench for the per-channel light filter and peak report.
// A short table of directed samples and register settings runs first. Rows
// whose report is obvious carry it typed in. Six random phases follow, each
// under its own weight and margin. Every sample transaction runs through a
// local copy of the filter and the scan. Each report popped from the output
// queue is compared, field by field, with the oldest predicted one. Both
// queue sides idle at random. One phase stalls the receiver long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_multichannel_light_peak_finder_unit;
  import mlpf_pkg::*;

  localparam int LEVELS      = 8;
  localparam int N_DIR       = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE      = 2 * (LEVELS + 17);
  localparam int DRAIN_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic [WEIGHT_BITS-1:0] weight;
    logic [LEVEL_BITS-1:0]  margin;
    logic                   typed;
    res_t                   want;
  } step_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_push    = 1'b0;
  logic                   in_full;
  logic [CH_BITS-1:0]     in_channel = '0;
  logic [SAMPLE_BITS-1:0] in_sample  = '0;
  logic                   out_empty;
  logic                   out_pop    = 1'b0;
  logic                   out_peak_found;
  logic [CH_BITS-1:0]     out_peak_channel;
  logic [LEVEL_BITS-1:0]  out_peak_value;
  logic [LEVEL_BITS-1:0]  out_mean_level;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Local model state
  logic [LEVEL_BITS-1:0]  chan_level [LEVELS];
  logic [WEIGHT_BITS-1:0] weight_reg = 8'd128;
  logic [LEVEL_BITS-1:0]  margin_reg = 10'd50;

  res_t      pending_reports [$];
  step_row_t dir_rows [N_DIR];
  int        errors      = 0;
  int        samples     = 0;
  int        reports     = 0;
  int        settings    = 1;
  bit        steady      = 1'b0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;
  int        hold_left   = 0;

  multichannel_light_peak_finder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_peak_found  (out_peak_found),
    .out_peak_channel(out_peak_channel),
    .out_peak_value  (out_peak_value),
    .out_mean_level  (out_mean_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Filter one sample into its channel; on the highest channel, walk all
  // levels and build the report. Returns 1 when a report is due.
  function automatic bit filter_and_scan(input logic [CH_BITS-1:0] ch,
                                         input logic [SAMPLE_BITS-1:0] s,
                                         output res_t rep);
    int unsigned acc;
    int unsigned sum;
    int unsigned best;
    int unsigned best_ch;
    int unsigned mean;
    rep = '0;
    if (int'(ch) >= LEVELS) begin
      return 1'b0;
    end
    acc = (256 - int'(weight_reg)) * int'(s) + int'(weight_reg) * int'(chan_level[ch]);
    chan_level[ch] = LEVEL_BITS'(acc >> 8);
    if (int'(ch) != LEVELS - 1) begin
      return 1'b0;
    end
    sum     = 0;
    best    = chan_level[0];
    best_ch = 0;
    for (int i = 0; i < LEVELS; i++) begin
      sum += chan_level[i];
      if (chan_level[i] > best) begin
        best    = chan_level[i];
        best_ch = i;
      end
    end
    mean = sum / LEVELS;
    if (best - mean >= int'(margin_reg)) begin
      rep.peak_found   = 1'b1;
      rep.peak_channel = CH_BITS'(best_ch);
      rep.peak_value   = LEVEL_BITS'(best);
    end
    rep.mean_level = LEVEL_BITS'(mean);
    return 1'b1;
  endfunction

  function automatic step_row_t sample_row(input int ch, input int s);
    step_row_t r;
    r         = '0;
    r.kind    = ROW_SAMPLE;
    r.channel = CH_BITS'(ch);
    r.sample  = SAMPLE_BITS'(s);
    return r;
  endfunction

  function automatic step_row_t typed_row(input int ch, input int s, input int f,
                                          input int pc, input int pv, input int ml);
    step_row_t r;
    r                   = sample_row(ch, s);
    r.typed             = 1'b1;
    r.want.peak_found   = f[0];
    r.want.peak_channel = CH_BITS'(pc);
    r.want.peak_value   = LEVEL_BITS'(pv);
    r.want.mean_level   = LEVEL_BITS'(ml);
    return r;
  endfunction

  function automatic step_row_t config_row(input int w, input int m);
    step_row_t r;
    r        = '0;
    r.kind   = ROW_CONFIG;
    r.weight = WEIGHT_BITS'(w);
    r.margin = LEVEL_BITS'(m);
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom_range(1023));
    endcase
  endfunction

  // Returns at the accepting edge with in_push still high, so a following
  // transaction can go out without a gap.
  task automatic send_sample(input logic [CH_BITS-1:0] ch,
                             input logic [SAMPLE_BITS-1:0] s,
                             input logic typed, input res_t want);
    res_t rep;
    while (!steady && $urandom_range(99) < 22) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_channel <= ch;
    in_sample  <= s;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    samples++;
    if (filter_and_scan(ch, s, rep)) begin
      pending_reports.push_back(typed ? want : rep);
    end
  endtask

  // Wait for every predicted report, then let the back end finish any
  // filter update still in flight.
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    in_push <= 1'b0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d scan reports expected, none arrived", $time,
               pending_reports.size());
      errors++;
      pending_reports.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [WEIGHT_BITS-1:0] w,
                            input logic [LEVEL_BITS-1:0] m);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FILTER_WEIGHT;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    weight_reg = w;
    cfg_index <= REG_PEAK_MARGIN;
    cfg_data  <= CFG_DATA_W'(m);
    @(posedge clk);
    margin_reg = m;
    cfg_we    <= 1'b0;
    settings++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: check each popped transaction, then pick the next pop.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        reports++;
        if (pending_reports.size() == 0) begin
          $display("%0t: report expected none, got found %0d ch %0d value %0d mean %0d",
                   $time, out_peak_found, out_peak_channel, out_peak_value,
                   out_mean_level);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("peak_found", want.peak_found, out_peak_found);
          check_field("peak_channel", want.peak_channel, out_peak_channel);
          check_field("peak_value", want.peak_value, out_peak_value);
          check_field("mean_level", want.mean_level, out_mean_level);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    logic [WEIGHT_BITS-1:0] w;
    logic [LEVEL_BITS-1:0]  m;
    int                     sent;
    for (int i = 0; i < LEVELS; i++) begin
      chan_level[i] = '0;
    end
    dir_rows = '{
      typed_row(7, 0, 0, 0, 0, 0),          // levels right after reset
      config_row(0, 0),                     // weight zero, zero margin
      typed_row(7, 0, 1, 0, 0, 0),          // all zero, flag still set
      sample_row(0, 1023),
      typed_row(7, 1023, 1, 0, 1023, 255),  // tie goes to the lower channel
      config_row(0, 1023),
      typed_row(7, 1023, 0, 0, 0, 255),     // margin not reached
      sample_row(1, 1023),
      sample_row(2, 1023),
      sample_row(3, 1023),
      sample_row(4, 1023),
      sample_row(5, 1023),
      sample_row(6, 1023),
      typed_row(7, 1023, 0, 0, 0, 1023),    // all levels at full scale
      config_row(0, 0),
      typed_row(7, 1023, 1, 0, 1023, 1023),
      config_row(255, 50),                  // heaviest weight on old level
      sample_row(3, 0),
      sample_row(7, 0),
      config_row(128, 50),
      sample_row(4, 682),
      sample_row(2, 341),
      sample_row(7, 512)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        drain_and_settle();
        set_config(dir_rows[i].weight, dir_rows[i].margin);
      end else begin
        send_sample(dir_rows[i].channel, dir_rows[i].sample, dir_rows[i].typed,
                    dir_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      w = WEIGHT_BITS'($urandom_range(255));
      m = LEVEL_BITS'($urandom_range(400));
      case (p)
        1: w = '0;
        2: w = '1;
        3: m = '0;
        4: m = '1;
        5: begin
          w = 8'd128;
          m = 10'd50;
        end
        default: ;
      endcase
      set_config(w, m);
      steady = (p == 3);
      if (p == 1) begin
        hold_req <= 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly full scans in channel order, the rest single stray samples
        if ($urandom_range(99) < 70) begin
          for (int c = 0; c < LEVELS; c++) begin
            send_sample(CH_BITS'(c), rand_sample(), 1'b0, '0);
          end
          sent += LEVELS;
        end else begin
          send_sample(CH_BITS'($urandom_range(LEVELS - 1)), rand_sample(), 1'b0, '0);
          sent++;
        end
      end
    end
    steady = 1'b0;
    drain_and_settle();

    $display("Sent %0d samples under %0d weight/margin settings, %0d scan reports popped",
             samples, settings, reports);
    $display("Included a %0d-cycle receiver stall and a phase with no idling",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
